// File: hdl/ptls_pkg.sv
// Shared constants, codes and types for the per-bank time list store.
package ptls_pkg;

  localparam int STATIONS     = 16;
  localparam int CAPACITY     = 64;
  localparam int RESULT_LIMIT = 64;
  localparam int MIN_PER_HOUR = 60;
  localparam int CFG_RESET    = 16;

  localparam int ST_W   = (STATIONS > 1) ? $clog2(STATIONS) : 1;
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = ST_W + IDX_W;
  localparam int DEPTH  = STATIONS << IDX_W;

  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int KEY_W   = HOUR_W + MIN_W;
  localparam int WAIT_W  = 11;
  localparam int LCNT_W  = 7;
  localparam int OCNT_W  = 7;
  localparam int CFG_W   = 5;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_STATION = 3'd1,
    ST_FULL        = 3'd2,
    ST_NOT_FOUND   = 3'd3,
    ST_BAD_COUNT   = 3'd4
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [HOUR_W-1:0]   hour;
    logic [MIN_W-1:0]    minute;
    logic [WAIT_W-1:0]   wait_min;
    logic [1:0]          platform;
    logic                entry_valid;
    logic [OCNT_W-1:0]   count;
    logic                last;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// File: hdl/ptls_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module ptls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/ptls_alu.sv
// Minute-of-day conversion with compare and difference against a reference.
module ptls_alu (
  input  logic [ptls_pkg::KEY_W-1:0] key_i,
  input  logic [ptls_pkg::KEY_W-1:0] ref_i,
  output logic [ptls_pkg::KEY_W-1:0] mins_o,
  output logic                       ge_o,
  output logic [ptls_pkg::KEY_W-1:0] diff_o
);

  import ptls_pkg::*;

  logic [KEY_W-1:0] hour_ext;
  logic [KEY_W-1:0] min_ext;

  assign hour_ext = KEY_W'(key_i[KEY_W-1:MIN_W]);
  assign min_ext  = KEY_W'(key_i[MIN_W-1:0]);
  // hour*60+minute never exceeds 1923, so it fits the key width
  assign mins_o   = hour_ext * KEY_W'(MIN_PER_HOUR) + min_ext;
  assign ge_o     = mins_o >= ref_i;
  assign diff_o   = mins_o - ref_i;

endmodule

// File: hdl/ptls_seq.sv
// Command sequencer: bank counts, entry scan/shift over the RAM, result register.
module ptls_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  cmd_i,
  input  logic [3:0]                  station_i,
  input  logic [ptls_pkg::HOUR_W-1:0] time_hour_i,
  input  logic [ptls_pkg::MIN_W-1:0]  time_minute_i,
  input  logic [ptls_pkg::LCNT_W-1:0] list_count_i,
  input  logic [ptls_pkg::CFG_W-1:0]  stations_in_use_i,
  output ptls_pkg::ram_req_t          ram_req_o,
  input  logic [ptls_pkg::KEY_W-1:0]  ram_rdata_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ptls_pkg::res_t              out_res_o
);

  import ptls_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REM_SCAN,
    S_REM_SHIFT,
    S_QRY_SCAN,
    S_LIST,
    S_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [ST_W-1:0]  st_q, st_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [CNT_W-1:0] lim_q, lim_d;
  logic [CNT_W-1:0] rd_q, rd_d;
  logic             pend_q, pend_d;
  logic [CNT_W-1:0] pend_idx_q, pend_idx_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [KEY_W-1:0] qmin_q, qmin_d;
  logic [1:0]       plat_q, plat_d;
  res_t             res_q, res_d;
  logic             out_valid_q, out_valid_d;
  res_t             out_q, out_d;
  logic [CNT_W-1:0] cnt_q [STATIONS];

  logic [ST_W-1:0]  in_st;
  logic [CNT_W-1:0] cur_cnt;
  logic             bad_st;
  logic [KEY_W-1:0] key_in;
  logic [KEY_W-1:0] alu_key;
  logic [KEY_W-1:0] alu_mins;
  logic             alu_ge;
  logic [KEY_W-1:0] alu_diff;
  logic             out_free;
  logic             can_rd;
  logic [CNT_W-1:0] wr_idx;
  logic [31:0]      avail32;
  logic             cw_en;
  logic [ST_W-1:0]  cw_idx;
  logic [CNT_W-1:0] cw_val;
  logic             ld;
  res_t             ld_res;
  ram_req_t         req;
  logic             list_last;

  function automatic res_t mk_res(status_e s, logic [KEY_W-1:0] k, logic [WAIT_W-1:0] w,
                                  logic [1:0] p, logic v, logic [CNT_W-1:0] c, logic l);
    res_t r;
    r.status      = s;
    r.hour        = k[KEY_W-1:MIN_W];
    r.minute      = k[MIN_W-1:0];
    r.wait_min    = w;
    r.platform    = p;
    r.entry_valid = v;
    r.count       = OCNT_W'(c);
    r.last        = l;
    return r;
  endfunction

  assign in_st   = station_i[ST_W-1:0];
  assign cur_cnt = cnt_q[in_st];
  assign bad_st  = ({1'b0, station_i} >= stations_in_use_i) || (32'(station_i) >= STATIONS);
  assign key_in  = {time_hour_i, time_minute_i};
  // the converter serves the query time at accept and stored entries during a scan
  assign alu_key = (state_q == S_IDLE) ? key_in : ram_rdata_i;

  ptls_alu u_alu (
    .key_i  (alu_key),
    .ref_i  (qmin_q),
    .mins_o (alu_mins),
    .ge_o   (alu_ge),
    .diff_o (alu_diff)
  );

  assign out_free  = !out_valid_q || !out_stall_i;
  assign can_rd    = rd_q < lim_q;
  assign wr_idx    = pend_idx_q - CNT_W'(1);
  assign list_last = (pend_idx_q + CNT_W'(1)) == lim_q;
  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    logic [31:0] lc32;
    logic [31:0] n32;
    lc32    = 32'(list_count_i);
    n32     = 32'(cur_cnt);
    avail32 = (lc32 < n32) ? lc32 : n32;
    if (avail32 > RESULT_LIMIT) begin
      avail32 = RESULT_LIMIT;
    end
  end

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    n_d        = n_q;
    lim_d      = lim_q;
    rd_d       = rd_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    key_d      = key_q;
    qmin_d     = qmin_q;
    plat_d     = plat_q;
    res_d      = res_q;
    req        = '0;
    cw_en      = 1'b0;
    cw_idx     = st_q;
    cw_val     = n_q;
    ld         = 1'b0;
    ld_res     = res_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          st_d   = in_st;
          n_d    = cur_cnt;
          key_d  = key_in;
          qmin_d = alu_mins;
          rd_d   = '0;
          plat_d = 2'd1;
          lim_d  = cur_cnt;
          state_d = S_EMIT;
          if (bad_st) begin
            res_d = mk_res(ST_BAD_STATION, '0, '0, 2'd0, 1'b0, '0, 1'b1);
          end else begin
            case (cmd_e'(cmd_i))
              CMD_ADD: begin
                if (32'(cur_cnt) >= CAPACITY) begin
                  res_d = mk_res(ST_FULL, '0, '0, 2'd0, 1'b0, cur_cnt, 1'b1);
                end else begin
                  req.we    = 1'b1;
                  req.waddr = {in_st, cur_cnt[IDX_W-1:0]};
                  req.wdata = key_in;
                  cw_en     = 1'b1;
                  cw_idx    = in_st;
                  cw_val    = cur_cnt + CNT_W'(1);
                  res_d = mk_res(ST_OK, '0, '0, 2'd0, 1'b0, cur_cnt + CNT_W'(1), 1'b1);
                end
              end
              CMD_REMOVE: state_d = S_REM_SCAN;
              CMD_QUERY:  state_d = S_QRY_SCAN;
              CMD_LIST: begin
                if (list_count_i == '0) begin
                  res_d = mk_res(ST_BAD_COUNT, '0, '0, 2'd0, 1'b0, cur_cnt, 1'b1);
                end else if (avail32 == 32'd0) begin
                  res_d = mk_res(ST_OK, '0, '0, 2'd0, 1'b0, cur_cnt, 1'b1);
                end else begin
                  lim_d   = CNT_W'(avail32);
                  state_d = S_LIST;
                end
              end
              default: state_d = S_EMIT;
            endcase
          end
        end
      end

      S_REM_SCAN, S_REM_SHIFT, S_QRY_SCAN: begin
        req.re     = can_rd;
        req.raddr  = {st_q, rd_q[IDX_W-1:0]};
        pend_d     = can_rd;
        pend_idx_d = rd_q;
        if (can_rd) begin
          rd_d = rd_q + CNT_W'(1);
        end
        if (state_q == S_REM_SCAN) begin
          if (pend_q && ram_rdata_i == key_q) begin
            // the read already in flight is the first entry to move down
            state_d = S_REM_SHIFT;
          end else if (!pend_q && !can_rd) begin
            res_d   = mk_res(ST_NOT_FOUND, '0, '0, 2'd0, 1'b0, n_q, 1'b1);
            state_d = S_EMIT;
          end
        end else if (state_q == S_REM_SHIFT) begin
          if (pend_q) begin
            req.we    = 1'b1;
            req.waddr = {st_q, wr_idx[IDX_W-1:0]};
            req.wdata = ram_rdata_i;
          end else if (!can_rd) begin
            cw_en   = 1'b1;
            cw_val  = n_q - CNT_W'(1);
            res_d   = mk_res(ST_OK, '0, '0, 2'd0, 1'b0, n_q - CNT_W'(1), 1'b1);
            state_d = S_EMIT;
          end
        end else begin
          if (pend_q && alu_ge) begin
            res_d   = mk_res(ST_OK, ram_rdata_i, alu_diff, 2'd0, 1'b1, n_q, 1'b1);
            state_d = S_EMIT;
          end else if (!pend_q && !can_rd) begin
            res_d   = mk_res(ST_NOT_FOUND, '0, '0, 2'd0, 1'b0, n_q, 1'b1);
            state_d = S_EMIT;
          end
        end
      end

      S_LIST: begin
        // one read ahead; a stalled output holds the read data in the RAM register
        req.raddr = {st_q, rd_q[IDX_W-1:0]};
        req.re    = can_rd && (!pend_q || out_free);
        if (req.re) begin
          pend_d     = 1'b1;
          pend_idx_d = rd_q;
          rd_d       = rd_q + CNT_W'(1);
        end else begin
          pend_d = pend_q && !out_free;
        end
        if (pend_q && out_free) begin
          ld     = 1'b1;
          ld_res = mk_res(ST_OK, ram_rdata_i, '0, plat_q, 1'b1, n_q, list_last);
          plat_d = (plat_q == 2'd3) ? 2'd1 : plat_q + 2'd1;
          if (list_last) begin
            state_d = S_IDLE;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_res  = res_q;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    out_valid_d = ld || (out_valid_q && out_stall_i);
    out_d       = ld ? ld_res : out_q;
  end

  assign ram_req_o = req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      st_q        <= '0;
      n_q         <= '0;
      lim_q       <= '0;
      rd_q        <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      key_q       <= '0;
      qmin_q      <= '0;
      plat_q      <= 2'd1;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int i = 0; i < STATIONS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      st_q        <= st_d;
      n_q         <= n_d;
      lim_q       <= lim_d;
      rd_q        <= rd_d;
      pend_q      <= pend_d;
      pend_idx_q  <= pend_idx_d;
      key_q       <= key_d;
      qmin_q      <= qmin_d;
      plat_q      <= plat_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      if (cw_en) begin
        cnt_q[cw_idx] <= cw_val;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

// File: hdl/per_bank_time_list_store.sv
// Top level: per-station time list store with config register, sequencer and entry RAM.
// Add, bad station and rejected list: the result is registered, then loaded into the output register.
// Remove: scan to the match, then shift the rest down one per cycle.
// Query: scans the bank; list: one entry per cycle while the output is not stalled.
// One item at a time; input stalls until the item's last result is in the output register.
// Reset clears all bank counts and sets stations_in_use to 16; RAM needs no clearing.
module per_bank_time_list_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ptls_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  cmd_i,
  input  logic [3:0]                  station_i,
  input  logic [ptls_pkg::HOUR_W-1:0] time_hour_i,
  input  logic [ptls_pkg::MIN_W-1:0]  time_minute_i,
  input  logic [ptls_pkg::LCNT_W-1:0] list_count_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic [ptls_pkg::HOUR_W-1:0] out_hour_o,
  output logic [ptls_pkg::MIN_W-1:0]  out_minute_o,
  output logic [ptls_pkg::WAIT_W-1:0] wait_minutes_o,
  output logic [1:0]                  platform_o,
  output logic                        entry_valid_o,
  output logic [ptls_pkg::OCNT_W-1:0] stored_count_o,
  output logic                        service_active_o,
  output logic                        last_o
);

  import ptls_pkg::*;

  logic [CFG_W-1:0] cfg_q;
  ram_req_t         ram_req;
  logic [KEY_W-1:0] ram_rdata;
  res_t             res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_W'(CFG_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  ptls_seq u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .station_i         (station_i),
    .time_hour_i       (time_hour_i),
    .time_minute_i     (time_minute_i),
    .list_count_i      (list_count_i),
    .stations_in_use_i (cfg_q),
    .ram_req_o         (ram_req),
    .ram_rdata_i       (ram_rdata),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_res_o         (res)
  );

  ptls_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  assign status_o         = res.status;
  assign out_hour_o       = res.hour;
  assign out_minute_o     = res.minute;
  assign wait_minutes_o   = res.wait_min;
  assign platform_o       = res.platform;
  assign entry_valid_o    = res.entry_valid;
  assign stored_count_o   = res.count;
  assign service_active_o = res.count != '0;
  assign last_o           = res.last;

`ifndef NO_ASSERTIONS
  // every accepted item makes the input stall in the cycle after the accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted again right after an accept");

  // only listed entries carry a platform number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && platform_o != 2'd0 |-> entry_valid_o && status_o == ST_OK)
    else $error("platform on a non-list result");

  // error results are single, final and carry no entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> last_o && !entry_valid_o)
    else $error("error result not final or carries an entry");

  // a rejected station reports an empty bank
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_BAD_STATION |-> stored_count_o == '0)
    else $error("bad station result with nonzero count");
`endif

endmodule
